FILE: hw/rtl/bkt_pkg.sv
package bkt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [15:0] MIN_DELAY_RST = 16'd2;
	localparam logic [15:0] MAX_DELAY_RST = 16'd60;
	localparam logic [15:0] GRACE_DELAY_RST = 16'd5;

	localparam logic [1:0] REG_MIN_DELAY = 2'd0;
	localparam logic [1:0] REG_MAX_DELAY = 2'd1;
	localparam logic [1:0] REG_GRACE_DELAY = 2'd2;

	localparam logic [7:0] FAILS_MAX = 8'hFF;
	localparam logic [4:0] SHIFT_MAX = 5'd16;

	typedef enum logic [1:0] {
		FN_CHECK = 2'd0,
		FN_FAIL  = 2'd1,
		FN_SUCC  = 2'd2,
		FN_SWEEP = 2'd3
	} func_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  fails;
		logic [31:0] next_try;
	} entry_t;

	typedef struct packed {
		logic [15:0] min_delay;
		logic [15:0] max_delay;
		logic [15:0] grace_delay;
	} cfg_t;

	typedef struct packed {
		logic        ready_res;
		logic [15:0] delay_set;
		logic        table_full;
		logic [7:0]  fail_count;
	} res_t;

	// min_delay doubled once per prior failure, capped at max_delay
	function automatic logic [15:0] calc_delay(
		input logic [7:0]  n,
		input logic [15:0] mn,
		input logic [15:0] mx
	);
		logic [7:0]  nm1;
		logic [4:0]  k;
		logic [31:0] shifted;
		nm1 = n - 8'd1;
		k = (nm1 > 8'(SHIFT_MAX)) ? SHIFT_MAX : nm1[4:0];
		shifted = 32'(mn) << k;
		calc_delay = (shifted > 32'(mx)) ? mx : shifted[15:0];
	endfunction

endpackage

FILE: hw/rtl/bkt_ram.sv
module bkt_ram
	import bkt_pkg::*;
(
	input  logic   clk,
	input  logic   we,
	input  logic   re,
	input  idx_t   addr,
	input  entry_t wr_data,
	output entry_t rd_data
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[addr];
		end
	end

endmodule

FILE: hw/rtl/bkt_ctrl.sv
module bkt_ctrl
	import bkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  func,
	input  logic [15:0] key,
	input  logic [31:0] now,
	output logic        res_valid,
	input  logic        res_take,
	output res_t        res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_CALC,
		S_WRITE,
		S_RESULT
	} state_t;

	state_t             state_q;
	func_t              func_q;
	logic [15:0]        key_q;
	logic [31:0]        now_q;
	logic [31:0]        floor_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] present_q;
	logic [CNT_W-1:0]   scan_cnt_q;
	logic               cmp_v_s1;
	idx_t               cmp_idx_s1;
	logic               hit_q;
	idx_t               hit_idx_q;
	entry_t             hit_entry_q;
	logic               free_q;
	idx_t               free_idx_q;
	idx_t               idx_q;
	logic [7:0]         fails_q;
	logic [15:0]        delay_q;
	res_t               res_q;

	logic               mem_we;
	logic               mem_re;
	idx_t               mem_addr;
	entry_t             mem_wr_data;
	entry_t             mem_rd_data;
	logic               have_entry;
	idx_t               entry_idx;
	logic [7:0]         base_fails;
	logic [7:0]         inc_fails;

	bkt_ram u_ram (
		.clk     (clk),
		.we      (mem_we),
		.re      (mem_re),
		.addr    (mem_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	assign mem_re = (state_q == S_SCAN) && (scan_cnt_q < CNT_W'(ENTRIES));
	assign mem_we = (state_q == S_WRITE);
	assign mem_addr = (state_q == S_SCAN) ? scan_cnt_q[IDX_W-1:0] : idx_q;
	assign mem_wr_data = '{key: key_q, fails: fails_q, next_try: now_q + 32'(delay_q)};

	assign have_entry = hit_q || (free_q && (key_q != 16'd0));
	assign entry_idx = hit_q ? hit_idx_q : free_idx_q;
	assign base_fails = hit_q ? hit_entry_q.fails : 8'd0;
	assign inc_fails = (base_fails == FAILS_MAX) ? FAILS_MAX : base_fails + 8'd1;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= FN_CHECK;
			key_q <= '0;
			now_q <= '0;
			floor_q <= '0;
			valid_q <= '0;
			present_q <= '0;
			scan_cnt_q <= '0;
			cmp_v_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_entry_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			idx_q <= '0;
			fails_q <= '0;
			delay_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q <= func_t'(func);
						key_q <= key;
						now_q <= now;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						scan_cnt_q <= '0;
						res_q <= '0;
						if (func_t'(func) == FN_SWEEP) begin
							valid_q <= valid_q & present_q;
							present_q <= '0;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_cnt_q < CNT_W'(ENTRIES)) begin
						cmp_v_s1 <= 1'b1;
						cmp_idx_s1 <= scan_cnt_q[IDX_W-1:0];
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end else begin
						cmp_v_s1 <= 1'b0;
						if (!cmp_v_s1) begin
							state_q <= S_EVAL;
						end
					end
					if (cmp_v_s1) begin
						if (valid_q[cmp_idx_s1] && (mem_rd_data.key == key_q) && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_idx_s1;
							hit_entry_q <= mem_rd_data;
						end
						if (!valid_q[cmp_idx_s1] && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
					end
				end
				S_EVAL: begin
					case (func_q)
						FN_CHECK: begin
							res_q.ready_res <= (now_q >= floor_q) &&
								!(hit_q && (now_q < hit_entry_q.next_try));
							res_q.fail_count <= base_fails;
							if (hit_q) begin
								present_q[hit_idx_q] <= 1'b1;
							end
							state_q <= S_RESULT;
						end
						FN_FAIL, FN_SUCC: begin
							if (have_entry) begin
								idx_q <= entry_idx;
								if (!hit_q) begin
									valid_q[free_idx_q] <= 1'b1;
									present_q[free_idx_q] <= 1'b1;
								end
								if (func_q == FN_FAIL) begin
									fails_q <= inc_fails;
									state_q <= S_CALC;
								end else begin
									fails_q <= 8'd0;
									delay_q <= cfg.grace_delay;
									state_q <= S_WRITE;
								end
							end else begin
								res_q.table_full <= 1'b1;
								if (func_q == FN_FAIL) begin
									floor_q <= now_q + 32'(cfg.max_delay);
									res_q.delay_set <= cfg.max_delay;
								end
								state_q <= S_RESULT;
							end
						end
						default: begin
							state_q <= S_RESULT;
						end
					endcase
				end
				S_CALC: begin
					delay_q <= calc_delay(fails_q, cfg.min_delay, cfg.max_delay);
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					res_q.delay_set <= delay_q;
					res_q.fail_count <= fails_q;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/per_key_retry_backoff_table.sv
// channel  signals                  dir  payload
// req      req_valid / req_ready    in   func, key, now
// rsp      rsp_valid / rsp_ready    out  ready_res, delay_set, table_full, fail_count
// cfg      cfg_we                   in   cfg_idx, cfg_data
//
// check walks scan, eval and result; success adds write, failure adds calc and write
// sweep goes straight to result; failure or success that finds no entry ends after eval
// the single read port of the entry memory is walked one entry per cycle
// reset clears all entries, marks and the global floor; registers return to 2, 60, 5
// one word waits in the output register while the next request is taken
module per_key_retry_backoff_table
	import bkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  func,
	input  logic [15:0] key,
	input  logic [31:0] now,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        ready_res,
	output logic [15:0] delay_set,
	output logic        table_full,
	output logic [7:0]  fail_count
);

	cfg_t cfg_q;
	res_t res;
	res_t rsp_q;
	logic rsp_valid_q;
	logic res_valid;
	logic res_take;
	logic res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{min_delay: MIN_DELAY_RST, max_delay: MAX_DELAY_RST,
				grace_delay: GRACE_DELAY_RST};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_DELAY: cfg_q.min_delay <= cfg_data;
				REG_MAX_DELAY: cfg_q.max_delay <= cfg_data;
				REG_GRACE_DELAY: cfg_q.grace_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	bkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.key       (key),
		.now       (now),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = !rsp_valid_q || rsp_ready;
	assign res_load = res_valid && res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q <= res;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign ready_res = rsp_q.ready_res;
	assign delay_set = rsp_q.delay_set;
	assign table_full = rsp_q.table_full;
	assign fail_count = rsp_q.fail_count;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word still in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp_valid || rsp_ready))
		else $error("output register overwritten before it was taken");

	a_result_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("result pending while controller idle");

	a_drop_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(rsp_ready))
		else $error("response word dropped without handshake");
`endif

endmodule
